[src/tps_pkg.sv]
// tps_pkg: shared types, command codes and the fixed pattern table of the
// tone pattern sequencer. No dependencies.
package tps_pkg;

  // One tone segment: frequency in Hz, tone length and trailing pause in ms
  typedef struct packed {
    logic [15:0] freq;
    logic [15:0] dur;
    logic [15:0] pause;
  } seg_t;

  // Command codes on the request channel
  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_PLAY = 2'd1,
    CMD_STOP = 2'd2
  } cmd_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PUSH2
  } state_t;

  // One result as it leaves the block
  typedef struct packed {
    logic        tone_write;
    logic [15:0] tone_freq;
    logic        accepted;
    logic        busy_res;
    logic        last;
  } res_t;

  // Load request for the output buffer
  typedef struct packed {
    logic push;
    logic two;
  } oq_push_t;

  // Per-cycle command to the segment cell chain
  typedef struct packed {
    logic shift;
    logic push;
  } cell_ctl_t;

  localparam logic [3:0] NUM_PATTERNS = 4'd13;

  // Number of segments in a pattern
  function automatic logic [1:0] pat_len(input logic [3:0] id);
    logic [1:0] len;
    case (id)
      4'd2, 4'd6, 4'd7, 4'd12: len = 2'd1;
      default:                 len = 2'd2;
    endcase
    return len;
  endfunction

  // Segment idx (0 or 1) of a pattern; unused slots read as zero
  function automatic seg_t pat_seg(input logic [3:0] id, input logic idx);
    seg_t s;
    case ({id, idx})
      5'd0:    s = '{16'd900,  16'd120, 16'd30};
      5'd1:    s = '{16'd1200, 16'd120, 16'd0};
      5'd2:    s = '{16'd800,  16'd80,  16'd20};
      5'd4:    s = '{16'd1500, 16'd150, 16'd0};
      5'd6:    s = '{16'd1400, 16'd100, 16'd20};
      5'd7:    s = '{16'd1700, 16'd160, 16'd0};
      5'd8:    s = '{16'd1300, 16'd120, 16'd20};
      5'd9:    s = '{16'd1800, 16'd180, 16'd0};
      5'd10:   s = '{16'd900,  16'd160, 16'd30};
      5'd11:   s = '{16'd600,  16'd200, 16'd0};
      5'd12:   s = '{16'd500,  16'd500, 16'd0};
      5'd14:   s = '{16'd880,  16'd140, 16'd0};
      5'd16:   s = '{16'd720,  16'd80,  16'd30};
      5'd17:   s = '{16'd1180, 16'd130, 16'd0};
      5'd18:   s = '{16'd520,  16'd120, 16'd40};
      5'd19:   s = '{16'd320,  16'd160, 16'd0};
      5'd20:   s = '{16'd940,  16'd100, 16'd20};
      5'd21:   s = '{16'd1420, 16'd150, 16'd0};
      5'd22:   s = '{16'd620,  16'd140, 16'd20};
      5'd23:   s = '{16'd360,  16'd200, 16'd0};
      5'd24:   s = '{16'd1800, 16'd40,  16'd0};
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

[src/tps_cell.sv]
// tps_cell: one slot of the segment queue chain. Loads a new segment when it is
// the first free slot, or takes its upstream neighbor's segment on a pop.
// Depends on tps_pkg.
module tps_cell
  import tps_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [CNT_W-1:0] fill,
  input  seg_t             push_seg,
  input  seg_t             next_seg,
  output seg_t             seg
);

  seg_t seg_r;

  // pop moves the whole chain one slot toward the head
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      seg_r <= next_seg;
    end else if (ctl.push && (fill == CNT_W'(IDX))) begin
      seg_r <= push_seg;
    end
  end

  assign seg = seg_r;

endmodule

[src/tps_outq.sv]
// tps_outq: two-entry result buffer between the sequencer and the result port.
// Loaded only when empty, with one or two results at once. Depends on tps_pkg.
module tps_outq
  import tps_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  oq_push_t load,
  input  res_t     res0,
  input  res_t     res1,
  output logic     empty,
  output logic     out_valid,
  input  logic     out_stall,
  output res_t     out_res
);

  res_t       q0_r, q1_r;
  logic [1:0] cnt_r;
  logic       pop;

  assign pop       = (cnt_r != 2'd0) && !out_stall;
  assign empty     = (cnt_r == 2'd0);
  assign out_valid = !empty;
  assign out_res   = q0_r;

  // occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load.push && empty) begin
      cnt_r <= load.two ? 2'd2 : 2'd1;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load.push && empty) begin
      q0_r <= res0;
      q1_r <= res1;
    end else if (pop) begin
      q0_r <= q1_r;
    end
  end

endmodule

[src/tone_pattern_sequencer_core.sv]
// Tone pattern sequencer: plays fixed buzzer patterns from a segment queue
// driven by play, stop and millisecond tick requests.
// Depends on tps_pkg, tps_cell, tps_outq.

// Each request is taken in ST_IDLE and worked off in ST_EXEC, which first
// waits until the two-entry result buffer has drained; a two-segment play
// then passes through ST_PUSH2 for the second write into the segment queue.
// Segments queue in a chain of FIFO_DEPTH cells where the head is always
// cell 0: a play writes at the first free cell, and starting a segment shifts
// the whole chain by one. Every request gives one or two results, the final
// one flagged by out_last; a tick can give two tone writes (silence at the
// end of a tone, then the next segment's frequency).
module tone_pattern_sequencer_core
  import tps_pkg::*;
#(
  parameter int FIFO_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [3:0]  in_pattern_id,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_tone_write,
  output logic [15:0] out_tone_freq,
  output logic        out_accepted,
  output logic        out_busy_res,
  output logic        out_last
);

  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(FIFO_DEPTH);

  state_t           state_r, state_nxt;
  cmd_t             cmd_r;
  logic [3:0]       pid_r;
  logic [31:0]      now_r;
  logic             active_r, active_nxt;
  logic             pausing_r, pausing_nxt;
  seg_t             cur_r, cur_nxt;
  logic [31:0]      ss_r, ss_nxt;
  logic [31:0]      ps_r, ps_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  cell_ctl_t        cell_ctl;
  seg_t             push_seg;
  seg_t             seg_w [FIFO_DEPTH+1];
  seg_t             head;

  oq_push_t         oq_load;
  res_t             res0, res1;
  res_t             out_res;
  logic             oq_empty;

  logic             accept;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);
  assign head     = seg_w[0];

  // segment queue: row of cells, cell 0 is the head
  genvar gi;
  generate
    for (gi = 0; gi < FIFO_DEPTH; gi++) begin : g_cell
      tps_cell #(
        .IDX   (gi),
        .CNT_W (CNT_W)
      ) u_cell (
        .clk      (clk),
        .ctl      (cell_ctl),
        .fill     (count_r),
        .push_seg (push_seg),
        .next_seg (seg_w[gi+1]),
        .seg      (seg_w[gi])
      );
    end
  endgenerate
  assign seg_w[FIFO_DEPTH] = seg_w[FIFO_DEPTH-1];

  // result buffer
  tps_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (oq_load),
    .res0      (res0),
    .res1      (res1),
    .empty     (oq_empty),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_tone_write = out_res.tone_write;
  assign out_tone_freq  = out_res.tone_freq;
  assign out_accepted   = out_res.accepted;
  assign out_busy_res   = out_res.busy_res;
  assign out_last       = out_res.last;

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_t'(in_cmd);
      pid_r <= in_pattern_id;
      now_r <= in_now_ms;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      active_r  <= 1'b0;
      pausing_r <= 1'b0;
      count_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      active_r  <= active_nxt;
      pausing_r <= pausing_nxt;
      count_r   <= count_nxt;
    end
  end

  // segment timing payload
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    ss_r  <= ss_nxt;
    ps_r  <= ps_nxt;
  end

  // next state, queue control and results
  always_comb begin
    logic [31:0]      diff;
    logic [15:0]      thr;
    logic             done;
    logic             end_seg;
    logic [1:0]       nw;
    logic [15:0]      f0, f1;
    logic             acc;
    logic [1:0]       len;
    logic [CNT_W-1:0] room;
    logic             busy;

    state_nxt   = state_r;
    active_nxt  = active_r;
    pausing_nxt = pausing_r;
    cur_nxt     = cur_r;
    ss_nxt      = ss_r;
    ps_nxt      = ps_r;
    count_nxt   = count_r;
    cell_ctl    = '0;
    push_seg    = pat_seg(pid_r, state_r == ST_PUSH2);
    oq_load     = '0;
    res0        = '0;
    res1        = '0;
    busy        = 1'b0;
    nw          = 2'd0;
    f0          = 16'd0;
    f1          = 16'd0;
    acc         = 1'b0;
    end_seg     = 1'b0;
    len         = pat_len(pid_r);
    room        = DEPTH_C - count_r;

    // one subtract/compare serves both the tone and the pause phase
    diff = now_r - (pausing_r ? ps_r : ss_r);
    thr  = pausing_r ? cur_r.pause : cur_r.dur;
    done = (diff >= {16'd0, thr});

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (oq_empty) begin
          state_nxt = ST_IDLE;
          case (cmd_r)
            CMD_TICK: begin
              if (!active_r) begin
                // idle: start the head segment, if any
                if (count_r != '0) begin
                  cell_ctl.shift = 1'b1;
                  count_nxt      = count_r - CNT_W'(1);
                  cur_nxt        = head;
                  ss_nxt         = now_r;
                  pausing_nxt    = 1'b0;
                  active_nxt     = (head.dur != 16'd0);
                  nw             = 2'd1;
                  f0             = head.freq;
                end
              end else begin
                if (!pausing_r && done) begin
                  // tone over: silence, then pause or end
                  nw = 2'd1;
                  if (cur_r.pause != 16'd0) begin
                    pausing_nxt = 1'b1;
                    ps_nxt      = now_r;
                  end else begin
                    end_seg = 1'b1;
                  end
                end else if (pausing_r && done) begin
                  end_seg     = 1'b1;
                  pausing_nxt = 1'b0;
                end
                if (end_seg) begin
                  active_nxt = 1'b0;
                  if (count_r != '0) begin
                    cell_ctl.shift = 1'b1;
                    count_nxt      = count_r - CNT_W'(1);
                    cur_nxt        = head;
                    ss_nxt         = now_r;
                    pausing_nxt    = 1'b0;
                    active_nxt     = (head.dur != 16'd0);
                    if (nw == 2'd1) begin
                      f1 = head.freq;
                      nw = 2'd2;
                    end else begin
                      f0 = head.freq;
                      nw = 2'd1;
                    end
                  end
                end
              end
            end
            CMD_PLAY: begin
              acc = (pid_r < NUM_PATTERNS) && ({{(CNT_W-2){1'b0}}, len} <= room);
              if (acc) begin
                cell_ctl.push = 1'b1;
                count_nxt     = count_r + CNT_W'(1);
                if (len == 2'd2) begin
                  state_nxt = ST_PUSH2;
                end
              end
            end
            CMD_STOP: begin
              count_nxt   = '0;
              active_nxt  = 1'b0;
              pausing_nxt = 1'b0;
              nw          = 2'd1;
            end
            default: begin
            end
          endcase

          busy = active_nxt || (count_nxt != '0) || acc;

          oq_load.push = 1'b1;
          oq_load.two  = (nw == 2'd2);
          res0 = '{tone_write: (nw != 2'd0), tone_freq: f0, accepted: acc,
                   busy_res: busy, last: (nw != 2'd2)};
          res1 = '{tone_write: 1'b1, tone_freq: f1, accepted: acc,
                   busy_res: busy, last: 1'b1};
        end else begin
          res0 = '0;
          res1 = '0;
        end
      end

      ST_PUSH2: begin
        // second segment of a two-segment pattern
        cell_ctl.push = 1'b1;
        count_nxt     = count_r + CNT_W'(1);
        state_nxt     = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (state_r != ST_EXEC) begin
      res0 = '0;
      res1 = '0;
    end
  end

endmodule
